// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the triangle correction RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an active-low reset that disables it.
`define TLC_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Assertion on the block clock and reset.
`define TLC_ASSERT(label, prop, msg) \
    `TLC_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/tlc_pkg.sv =====
// ----------------------------------------------------------------------------
// tlc_pkg
// Widths, register indexes and shared types of the triangle correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int VAL_W  = 18;
    localparam int W_W    = 20;
    localparam int T_W    = 17;
    localparam int ACC_W  = 40;

    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 96;
    localparam int M_TUSER_W  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = W_W;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE_HIGH = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } tlc_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tlc_div.sv =====
// ----------------------------------------------------------------------------
// tlc_div
// Restoring serial divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module tlc_div import tlc_pkg::*; #(
    parameter int DVD_W = 44,
    parameter int DEN_W = 22,
    parameter int TOP_W = 17,
    localparam int Q_W  = DVD_W - TOP_W
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [DVD_W-1:0]   dividend,
    input  wire logic [DEN_W-1:0]   divisor,
    output logic      [Q_W-1:0]     quotient,
    output tlc_div_stat_t           stat
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial    = {rem_reg, quo_reg[Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DEN_W'(dividend[DVD_W-1 -: TOP_W]);
            quo_reg <= dividend[Q_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/triangle_likelihood_correct_top.sv =====
// ----------------------------------------------------------------------------
// triangle_likelihood_correct_top
// Triangle likelihood correction with a saturating running delta.
// ----------------------------------------------------------------------------
//  Channel | Dir | Content
//  s_      | in  | one triangle (ij, jk, ik) and the clear flag per beat
//  m_      | out | corrected triangle, flags and running delta per beat
//  cfg_    | in  | write-only register port: weight, threshold, mode
//
//  A skipped or unviolated triangle is repeated unchanged.
//  A corrected triangle runs the serial divider once for each of the three
//  new sides; the divider delivers one quotient bit per cycle, Q bits in all,
//  with Q = 2*max(F,20)+3-F.
//  The input is ready only while the sequencer is idle; a waiting result
//  beat does not block the next input beat until its own result is due.
//  Reset is synchronous and active low; it clears the delta and restores the
//  register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module triangle_likelihood_correct_top import tlc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // ij_value[17:0], jk_value[35:18], ik_value[53:36]
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // clear_delta[0]
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // new_ij[17:0], new_jk[35:18], new_ik[53:36], delta_total[93:54]
    output logic [M_TDATA_W-1:0]       m_tdata,
    // was_corrected[0], was_skipped[1]
    output logic [M_TUSER_W-1:0]       m_tuser,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int EXT_W = (FRAC_BITS > W_W) ? FRAC_BITS : W_W;
    localparam int MAG_W = 2 * EXT_W + 4;
    localparam int NUM_W = MAG_W + 1;
    localparam int DEN_W = EXT_W + 2;
    localparam int VIO_W = EXT_W + 3;
    localparam int TOP_W = FRAC_BITS + 1;
    localparam int Q_W   = MAG_W - TOP_W;
    localparam int PRD_W = EXT_W + VAL_W + 3;
    localparam int D_W   = VAL_W + 3;

    localparam logic [63:0] W_RST_FULL = 64'd4 << FRAC_BITS;
    localparam logic [63:0] T_RST_FULL = 64'd1 << (FRAC_BITS - 1);
    localparam logic [W_W-1:0] W_RST =
        (W_RST_FULL > 64'hFFFFF) ? {W_W{1'b1}} : W_RST_FULL[W_W-1:0];
    localparam logic [T_W-1:0] T_RST =
        (T_RST_FULL > 64'h1FFFF) ? {T_W{1'b1}} : T_RST_FULL[T_W-1:0];

    localparam logic [EXT_W:0]          ONE_U = (EXT_W + 1)'(64'd1 << FRAC_BITS);
    localparam logic signed [VIO_W-1:0] ONE_S = VIO_W'(64'd1 << FRAC_BITS);
    localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'(131071);
    localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(131072);
    localparam logic signed [VAL_W-1:0] VAL_MAX = 18'sh1FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 18'sh20000;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_RES   = 3'd5;
    localparam logic [2:0] ST_DELTA = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    localparam logic [1:0] SEL_B1 = 2'd0;
    localparam logic [1:0] SEL_B2 = 2'd1;
    localparam logic [1:0] SEL_S  = 2'd2;

    localparam logic [1:0] WH_IJ = 2'd0;
    localparam logic [1:0] WH_JK = 2'd1;
    localparam logic [1:0] WH_IK = 2'd2;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [W_W-1:0]           weight_reg;
    logic [T_W-1:0]           thresh_reg;
    logic                     mode_high_reg;
    logic [ACC_W-1:0]         acc_reg;

    logic signed [VAL_W-1:0]  ij_reg, jk_reg, ik_reg;
    logic signed [VAL_W-1:0]  s_reg, b1_reg, b2_reg;
    logic signed [VAL_W-1:0]  nb1_reg, nb2_reg, ns_reg;
    logic signed [VAL_W-1:0]  res_ij_reg, res_jk_reg, res_ik_reg;
    logic [1:0]               which_reg;
    logic [1:0]               sel_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic                     neg_reg;
    logic                     corr_flag_reg;
    logic                     skip_flag_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TUSER_W-1:0]     m_tuser_reg;

    logic                     s_accept;
    logic                     out_load;

    logic signed [VAL_W:0]    ij_ext;
    logic signed [VAL_W:0]    th_ext;
    logic                     skip;
    logic signed [VIO_W-1:0]  v1, v2, v3;
    logic                     viol;
    logic signed [VAL_W-1:0]  min_jk_ik, min_ij_ik;
    logic                     ij_small, jk_small;

    logic [DEN_W-1:0]         den;
    logic [EXT_W:0]           mul_a;
    logic signed [VAL_W:0]    mul_b;
    logic signed [PRD_W-1:0]  prod;
    logic signed [VIO_W-1:0]  corr;
    logic signed [NUM_W-1:0]  num;
    logic [MAG_W-1:0]         mag;
    logic [MAG_W-1:0]         dvd_in;
    logic                     div_start;
    logic [Q_W-1:0]           div_q;
    tlc_div_stat_t            div_stat;
    logic signed [VAL_W-1:0]  q_sat;

    logic signed [VAL_W:0]    dif1, dif2, dif3;
    logic [VAL_W:0]           abs1, abs2, abs3;
    logic [D_W-1:0]           dsum;
    logic [ACC_W:0]           acc_sum;
    logic [ACC_W-1:0]         acc_new;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Filter and bound check on the latched triangle.
    always_comb begin
        ij_ext    = (VAL_W + 1)'(ij_reg);
        th_ext    = $signed({2'b00, thresh_reg});
        skip      = mode_high_reg ? (ij_ext < th_ext) : (ij_ext > th_ext);
        v1        = VIO_W'(ij_reg) + VIO_W'(jk_reg) - VIO_W'(ik_reg) - ONE_S;
        v2        = VIO_W'(jk_reg) + VIO_W'(ik_reg) - VIO_W'(ij_reg) - ONE_S;
        v3        = VIO_W'(ik_reg) + VIO_W'(ij_reg) - VIO_W'(jk_reg) - ONE_S;
        viol      = (!v1[VIO_W-1] && (v1 != '0)) || (!v2[VIO_W-1] && (v2 != '0)) ||
                    (!v3[VIO_W-1] && (v3 != '0));
        min_jk_ik = (jk_reg < ik_reg) ? jk_reg : ik_reg;
        min_ij_ik = (ij_reg < ik_reg) ? ij_reg : ik_reg;
        ij_small  = (ij_reg < min_jk_ik);
        jk_small  = (jk_reg < min_ij_ik);
    end

    // Numerator of the selected side: one product plus a shifted term.
    always_comb begin
        den = {ONE_U, 1'b0} + DEN_W'(weight_reg);
        case (sel_reg)
            SEL_B1: begin
                mul_a = ONE_U + (EXT_W + 1)'(weight_reg);
                mul_b = (VAL_W + 1)'(b1_reg);
                corr  = ONE_S + VIO_W'(s_reg) - VIO_W'(b2_reg);
            end
            SEL_B2: begin
                mul_a = ONE_U + (EXT_W + 1)'(weight_reg);
                mul_b = (VAL_W + 1)'(b2_reg);
                corr  = ONE_S + VIO_W'(s_reg) - VIO_W'(b1_reg);
            end
            default: begin
                mul_a = (EXT_W + 1)'(weight_reg);
                mul_b = (VAL_W + 1)'(b1_reg) + (VAL_W + 1)'(b2_reg);
                corr  = VIO_W'(s_reg) + VIO_W'(s_reg) -
                        VIO_W'($signed({1'b0, weight_reg}));
            end
        endcase
        prod   = $signed({1'b0, mul_a}) * mul_b;
        num    = NUM_W'(prod) + (NUM_W'(corr) <<< FRAC_BITS);
        mag    = neg_reg ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        dvd_in = mag + MAG_W'(den >> 1);
    end

    assign div_start = (state_reg == ST_LOAD);

    tlc_div #(
        .DVD_W (MAG_W),
        .DEN_W (DEN_W),
        .TOP_W (TOP_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dvd_in),
        .divisor  (den),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Signed, saturated quotient.
    always_comb begin
        if (neg_reg) begin
            q_sat = (div_q > Q_NEG_MAX) ? VAL_MIN : VAL_W'(Q_W'(0) - div_q);
        end else begin
            q_sat = (div_q > Q_POS_MAX) ? VAL_MAX : VAL_W'(div_q);
        end
    end

    // Absolute changes and the saturating accumulator.
    always_comb begin
        dif1    = (VAL_W + 1)'(nb1_reg) - (VAL_W + 1)'(b1_reg);
        dif2    = (VAL_W + 1)'(nb2_reg) - (VAL_W + 1)'(b2_reg);
        dif3    = (VAL_W + 1)'(ns_reg) - (VAL_W + 1)'(s_reg);
        abs1    = dif1[VAL_W] ? unsigned'(-dif1) : unsigned'(dif1);
        abs2    = dif2[VAL_W] ? unsigned'(-dif2) : unsigned'(dif2);
        abs3    = dif3[VAL_W] ? unsigned'(-dif3) : unsigned'(dif3);
        dsum    = D_W'(abs1) + D_W'(abs2) + D_W'(abs3);
        acc_sum = {1'b0, acc_reg} + (ACC_W + 1)'(dsum);
        acc_new = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_CALC;
            ST_CALC:  state_next = (skip || !viol) ? ST_DONE : ST_NUM;
            ST_NUM:   state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   if (div_stat.done) state_next = ST_RES;
            ST_RES:   state_next = (sel_reg == SEL_S) ? ST_DELTA : ST_NUM;
            ST_DELTA: state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            weight_reg    <= W_RST;
            thresh_reg    <= T_RST;
            mode_high_reg <= 1'b1;
            acc_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WEIGHT:    weight_reg    <= cfg_data;
                    REG_THRESHOLD: thresh_reg    <= cfg_data[T_W-1:0];
                    REG_MODE_HIGH: mode_high_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_accept && s_tuser[0]) begin
                acc_reg <= '0;
            end else if (state_reg == ST_DELTA) begin
                acc_reg <= acc_new;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ij_reg <= $signed(s_tdata[17:0]);
            jk_reg <= $signed(s_tdata[35:18]);
            ik_reg <= $signed(s_tdata[53:36]);
        end
        case (state_reg)
            ST_CALC: begin
                res_ij_reg    <= ij_reg;
                res_jk_reg    <= jk_reg;
                res_ik_reg    <= ik_reg;
                skip_flag_reg <= skip;
                corr_flag_reg <= !skip && viol;
                sel_reg       <= SEL_B1;
                if (ij_small) begin
                    which_reg <= WH_IJ;
                    s_reg     <= ij_reg;
                    b1_reg    <= jk_reg;
                    b2_reg    <= ik_reg;
                end else if (jk_small) begin
                    which_reg <= WH_JK;
                    s_reg     <= jk_reg;
                    b1_reg    <= ij_reg;
                    b2_reg    <= ik_reg;
                end else begin
                    which_reg <= WH_IK;
                    s_reg     <= ik_reg;
                    b1_reg    <= jk_reg;
                    b2_reg    <= ij_reg;
                end
            end
            ST_NUM: begin
                num_reg <= num;
                neg_reg <= num[NUM_W-1];
            end
            ST_RES: begin
                case (sel_reg)
                    SEL_B1:  nb1_reg <= q_sat;
                    SEL_B2:  nb2_reg <= q_sat;
                    default: ns_reg  <= q_sat;
                endcase
                sel_reg <= sel_reg + 2'd1;
            end
            ST_DELTA: begin
                case (which_reg)
                    WH_IJ: begin
                        res_ij_reg <= ns_reg;
                        res_jk_reg <= nb1_reg;
                        res_ik_reg <= nb2_reg;
                    end
                    WH_JK: begin
                        res_jk_reg <= ns_reg;
                        res_ij_reg <= nb1_reg;
                        res_ik_reg <= nb2_reg;
                    end
                    default: begin
                        res_ik_reg <= ns_reg;
                        res_jk_reg <= nb1_reg;
                        res_ij_reg <= nb2_reg;
                    end
                endcase
            end
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= {2'b00, acc_reg, res_ik_reg, res_jk_reg, res_ij_reg};
            m_tuser_reg <= {skip_flag_reg, corr_flag_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TLC_ASSERT(a_div_busy_in_div, div_stat.busy |-> (state_reg == ST_DIV), "divider busy outside DIV")
    `TLC_ASSERT(a_res_after_done, (state_reg == ST_RES) |-> $past(div_stat.done), "RES without quotient")
    `TLC_ASSERT(a_clear_delta, (s_accept && s_tuser[0]) |=> (acc_reg == '0), "delta not cleared")
    `TLC_ASSERT(a_out_from_done, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_DONE), "stray beat")

endmodule

`default_nettype wire
